FILE: rtl/core/sxyp_pkg.sv
// Types and constants for the stereo XY plot point block.
// Item structs, fixed-point constants and the square-root step.
// No dependencies.
package sxyp_pkg;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } out_item_t;

  // Configuration register indexes
  localparam logic [7:0] REG_RAINBOW     = 8'd0;
  localparam logic [7:0] REG_FIXED_RED   = 8'd1;
  localparam logic [7:0] REG_FIXED_GREEN = 8'd2;
  localparam logic [7:0] REG_FIXED_BLUE  = 8'd3;

  // round(mag * 16384 / 30000) == floor((mag * 2048 + 1875) / 3750)
  localparam logic [26:0] ROUND_OFS  = 27'd1875;
  localparam logic [11:0] DIV_DEN    = 12'd3750;
  // floor(2^32 / 3750): estimate is exact or one low
  localparam logic [20:0] DIV_RECIP  = 21'd1145324;
  localparam int          RECIP_SHIFT = 32;

  localparam logic [14:0] POS_MAX = 15'd17896;

  // Square root: 14 result bits, two per stage
  localparam int SQ_BITS  = 14;
  localparam int SQ_STEPS = 2;
  localparam int SQ_STAGES = SQ_BITS / SQ_STEPS;

  // Hue sectors
  localparam logic [2:0] SEC_RED_GRN = 3'd0;
  localparam logic [2:0] SEC_GRN_RED = 3'd1;
  localparam logic [2:0] SEC_GRN_BLU = 3'd2;
  localparam logic [2:0] SEC_BLU_GRN = 3'd3;
  localparam logic [2:0] SEC_BLU_RED = 3'd4;
  localparam logic [2:0] SEC_RED_BLU = 3'd5;

  typedef struct packed {
    logic [16:0] rem;
    logic [13:0] root;
    logic [27:0] rad;   // radicand bits still to consume, MSB first
    logic        big;   // radius at or beyond one
  } sq_t;

  // One digit-by-digit square-root step
  function automatic sq_t sqrt_iter(sq_t a);
    sq_t         o;
    logic [16:0] rs;
    logic [16:0] tr;
    rs = {a.rem[14:0], a.rad[27:26]};
    tr = {1'b0, a.root, 2'b01};
    o = a;
    o.rad = {a.rad[25:0], 2'b00};
    if (rs >= tr) begin
      o.rem  = rs - tr;
      o.root = {a.root[12:0], 1'b1};
    end else begin
      o.rem  = rs;
      o.root = {a.root[12:0], 1'b0};
    end
    return o;
  endfunction

endpackage

FILE: rtl/core/stereo_xy_point_with_radius_hue.sv
// Stereo XY plot point with radius hue: top level, whole pipeline.
// Uses sxyp_pkg for item types, constants and the square-root step.
//
// Takes one stereo pair per clock (busy stays low) and gives its plot point and
// colour as a one-cycle out_valid strobe; the receiver cannot stall. The
// pipeline holds the position divide (three stages), the radius sum of squares
// (two) and the square root, which resolves two bits per stage over seven
// stages, then two colour stages. Configuration writes are always taken;
// change them only when no item is in flight.
module stereo_xy_point_with_radius_hue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sxyp_pkg::in_item_t  in_data,
  output logic                out_valid,
  output sxyp_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  localparam int PIPE_DEPTH = 13;               // stages ahead of the output register
  localparam int POS_DEPTH  = PIPE_DEPTH - 2;   // position known from stage 3

  logic accept;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration
  logic       rainbow_r;
  logic [7:0] fix_red_r, fix_green_r, fix_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rainbow_r   <= 1'b0;
      fix_red_r   <= 8'hff;
      fix_green_r <= 8'hff;
      fix_blue_r  <= 8'hff;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sxyp_pkg::REG_RAINBOW:     rainbow_r   <= cfg_data[0];
        sxyp_pkg::REG_FIXED_RED:   fix_red_r   <= cfg_data;
        sxyp_pkg::REG_FIXED_GREEN: fix_green_r <= cfg_data;
        sxyp_pkg::REG_FIXED_BLUE:  fix_blue_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [PIPE_DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], accept};
    end
  end

  // Stage 1: magnitude and scaled numerator, lane 0 is x, lane 1 is y
  logic signed [15:0] smp [2];
  logic [26:0]        num_nxt [2];
  logic [26:0]        num_r   [2];
  logic [1:0]         neg_r;

  assign smp[0] = in_data.left_sample;
  assign smp[1] = in_data.right_sample;

  always_comb begin
    logic signed [16:0] ext;
    logic [16:0]        mag;
    for (int i = 0; i < 2; i++) begin
      ext = {smp[i][15], smp[i]};
      mag = ext[16] ? 17'(-ext) : 17'(ext);
      num_nxt[i] = {mag[15:0], 11'b0} + sxyp_pkg::ROUND_OFS;
    end
  end

  always_ff @(posedge clk) begin
    num_r[0] <= num_nxt[0];
    num_r[1] <= num_nxt[1];
    neg_r    <= {smp[1][15], smp[0][15]};
  end

  // Stage 2: quotient estimate by reciprocal
  logic [26:0] num2_r [2];
  logic [15:0] qe_r   [2];
  logic [1:0]  neg2_r;

  always_ff @(posedge clk) begin
    logic [47:0] prod;
    for (int i = 0; i < 2; i++) begin
      prod      = 48'(num_r[i]) * 48'(sxyp_pkg::DIV_RECIP);
      qe_r[i]   <= prod[sxyp_pkg::RECIP_SHIFT +: 16];
      num2_r[i] <= num_r[i];
    end
    neg2_r <= neg_r;
  end

  // Stage 3: one-step correction, apply sign; position then rides along
  logic [14:0] abs_r [2];
  logic signed [15:0] pos_r [POS_DEPTH][2];

  always_ff @(posedge clk) begin
    logic [27:0] qm;
    logic [26:0] rem;
    logic [14:0] q;
    for (int i = 0; i < 2; i++) begin
      qm  = 28'(qe_r[i]) * 28'(sxyp_pkg::DIV_DEN);
      rem = num2_r[i] - qm[26:0];
      q   = (rem >= 27'(sxyp_pkg::DIV_DEN)) ? qe_r[i][14:0] + 15'd1 : qe_r[i][14:0];
      abs_r[i]    <= q;
      pos_r[0][i] <= neg2_r[i] ? 16'(16'd0 - {1'b0, q}) : {1'b0, q};
    end
    for (int k = 1; k < POS_DEPTH; k++) begin
      pos_r[k] <= pos_r[k-1];
    end
  end

  // Stage 4: squares
  logic [29:0] sqx_r, sqy_r;

  always_ff @(posedge clk) begin
    sqx_r <= 30'(abs_r[0]) * 30'(abs_r[0]);
    sqy_r <= 30'(abs_r[1]) * 30'(abs_r[1]);
  end

  // Stage 5: radius squared in Q2.28, set up the root
  sxyp_pkg::sq_t sq_r [sxyp_pkg::SQ_STAGES + 1];

  always_ff @(posedge clk) begin
    logic [29:0] s;
    s = sqx_r + sqy_r;
    sq_r[0].rem  <= '0;
    sq_r[0].root <= '0;
    sq_r[0].rad  <= s[27:0];
    sq_r[0].big  <= |s[29:28];
  end

  // Stages 6..12: square root, two result bits per stage
  for (genvar k = 0; k < sxyp_pkg::SQ_STAGES; k++) begin : g_sqrt
    sxyp_pkg::sq_t step;
    always_comb begin
      step = sq_r[k];
      for (int j = 0; j < sxyp_pkg::SQ_STEPS; j++) begin
        step = sxyp_pkg::sqrt_iter(step);
      end
    end
    always_ff @(posedge clk) begin
      sq_r[k+1] <= step;
    end
  end

  // Stage 13: hue = 6r, sector and fraction
  logic [2:0]  sec_r;
  logic [13:0] frac_r;
  logic        big_r;

  always_ff @(posedge clk) begin
    logic [16:0] h;
    h = 17'({sq_r[sxyp_pkg::SQ_STAGES].root, 2'b00})
      + 17'({sq_r[sxyp_pkg::SQ_STAGES].root, 1'b0});
    sec_r  <= h[16:14];
    frac_r <= h[13:0];
    big_r  <= sq_r[sxyp_pkg::SQ_STAGES].big;
  end

  // Output stage: channel ramp and sector pattern
  sxyp_pkg::out_item_t out_nxt;
  logic                out_valid_r;
  sxyp_pkg::out_item_t out_data_r;

  always_comb begin
    logic [21:0] ramp;
    logic [7:0]  f8;
    logic [7:0]  q8;
    ramp = 22'({frac_r, 8'b0}) - 22'(frac_r) + 22'd8192;
    f8   = ramp[21:14];
    q8   = 8'hff - f8;
    out_nxt.x_pos = pos_r[POS_DEPTH-1][0];
    out_nxt.y_pos = pos_r[POS_DEPTH-1][1];
    out_nxt.red   = fix_red_r;
    out_nxt.green = fix_green_r;
    out_nxt.blue  = fix_blue_r;
    if (rainbow_r) begin
      if (big_r) begin
        // at or beyond unit radius: pure red, no wrap
        out_nxt.red = 8'hff; out_nxt.green = 8'h00; out_nxt.blue = 8'h00;
      end else begin
        case (sec_r)
          sxyp_pkg::SEC_RED_GRN: begin
            out_nxt.red = 8'hff; out_nxt.green = f8;    out_nxt.blue = 8'h00;
          end
          sxyp_pkg::SEC_GRN_RED: begin
            out_nxt.red = q8;    out_nxt.green = 8'hff; out_nxt.blue = 8'h00;
          end
          sxyp_pkg::SEC_GRN_BLU: begin
            out_nxt.red = 8'h00; out_nxt.green = 8'hff; out_nxt.blue = f8;
          end
          sxyp_pkg::SEC_BLU_GRN: begin
            out_nxt.red = 8'h00; out_nxt.green = q8;    out_nxt.blue = 8'hff;
          end
          sxyp_pkg::SEC_BLU_RED: begin
            out_nxt.red = f8;    out_nxt.green = 8'h00; out_nxt.blue = 8'hff;
          end
          default: begin
            out_nxt.red = 8'hff; out_nxt.green = 8'h00; out_nxt.blue = q8;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (abs_r[0] <= sxyp_pkg::POS_MAX && abs_r[1] <= sxyp_pkg::POS_MAX))
    else $error("scaled position out of range");

  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[PIPE_DEPTH-2] |->
      (sq_r[sxyp_pkg::SQ_STAGES].rem <= 17'({sq_r[sxyp_pkg::SQ_STAGES].root, 1'b0})))
    else $error("square root remainder too large");

  a_hue_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && rainbow_r) |->
      (out_data.red == 8'hff || out_data.green == 8'hff || out_data.blue == 8'hff))
    else $error("hue colour lacks a full channel");

  a_hue_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && rainbow_r) |->
      (out_data.red == 8'h00 || out_data.green == 8'h00 || out_data.blue == 8'h00))
    else $error("hue colour lacks a dark channel");

endmodule
